// ----- design/depth_tested_pixel_store_assert.svh -----
`ifndef DEPTH_TESTED_PIXEL_STORE_ASSERT_SVH
`define DEPTH_TESTED_PIXEL_STORE_ASSERT_SVH

// Checks that a condition implies another one in the same cycle.
`define DTPS_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pixel store check failed");

// Checks that a condition implies another one in the following cycle.
`define DTPS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pixel store check failed");

`endif

// ----- design/dtps_pkg.sv -----
package dtps_pkg;

  localparam int CFG_W          = 9;
  localparam int CFG_IDX_W      = 1;
  localparam int COORD_W        = 8;
  localparam int COLOR_W        = 8;
  localparam int DEPTH_BITS     = 16;
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam logic [CFG_W-1:0] ACTIVE_WIDTH_RST  = CFG_W'(256);
  localparam logic [CFG_W-1:0] ACTIVE_HEIGHT_RST = CFG_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_WIDTH  = 1'b0,
    REG_ACTIVE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_CLEAR,
    ST_READ,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic latch;
    logic calc;
    logic clear_step;
    logic mem_rd;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  op;
    logic clear_done;
    logic out_free;
  } dp_status_t;

endpackage

// ----- design/dtps_ctrl.sv -----
`include "depth_tested_pixel_store_assert.svh"

module dtps_ctrl
  import dtps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: begin
        unique case (status_i.op) inside
          OP_CLEAR:          state_d = ST_CLEAR;
          OP_WRITE, OP_READ: state_d = ST_READ;
          default:           state_d = ST_EXEC;
        endcase
      end
      ST_CLEAR: begin
        if (status_i.clear_done) begin
          state_d = ST_EXEC;
        end
      end
      ST_READ: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.latch  = in_valid_i;
      end
      ST_ADDR: begin
        cmd_o.calc = 1'b1;
      end
      ST_CLEAR: begin
        cmd_o.clear_step = !status_i.clear_done;
      end
      ST_READ: begin
        cmd_o.mem_rd = 1'b1;
      end
      ST_EXEC: begin
        cmd_o.exec = status_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  `DTPS_ASSERT_NEXT(a_accept_to_addr, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q == ST_ADDR)
  `DTPS_ASSERT_NEXT(a_exec_to_idle, clk_i, rst_ni, cmd_o.exec, state_q == ST_IDLE)
  `DTPS_ASSERT_NEXT(a_clear_exit, clk_i, rst_ni, state_q == ST_CLEAR && status_i.clear_done, state_q == ST_EXEC)

endmodule

// ----- design/dtps_datapath.sv -----
`include "depth_tested_pixel_store_assert.svh"

module dtps_datapath
  import dtps_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic [1:0]            op_i,
  input  logic [COORD_W-1:0]    pixel_x_i,
  input  logic [COORD_W-1:0]    pixel_y_i,
  input  logic [DEPTH_BITS-1:0] depth_in_i,
  input  logic [COLOR_W-1:0]    red_in_i,
  input  logic [COLOR_W-1:0]    green_in_i,
  input  logic [COLOR_W-1:0]    blue_in_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COLOR_W-1:0]    red_out_o,
  output logic [COLOR_W-1:0]    green_out_o,
  output logic [COLOR_W-1:0]    blue_out_o,
  output logic [DEPTH_BITS-1:0] depth_out_o,
  output logic                  pixel_updated_o,
  output logic                  out_of_range_o
);

  localparam int WW     = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int WH     = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
  localparam int PW     = COORD_W + WW;
  localparam int STORE  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW0    = $clog2(STORE);
  localparam int ADDR_W = (AW0 < 1) ? 1 : AW0;
  localparam int EW     = (PW > ADDR_W) ? PW : ADDR_W;
  localparam int TW     = WW + WH;
  localparam int PIX_W  = 3 * COLOR_W;

  logic [CFG_W-1:0]      width_q, height_q;
  op_e                   op_q;
  logic [COORD_W-1:0]    x_q, y_q;
  logic [DEPTH_BITS-1:0] z_q;
  logic [PIX_W-1:0]      color_q;

  logic [WW-1:0]         eff_w;
  logic [WH-1:0]         eff_h;
  logic                  inside_d, inside_q;
  logic [EW-1:0]         addr_ext;
  logic [ADDR_W-1:0]     addr_q;
  logic [TW-1:0]         total_d, total_q;
  logic [TW-1:0]         cursor_q;

  logic [PIX_W-1:0]      color_mem [STORE];
  logic [DEPTH_BITS-1:0] depth_mem [STORE];
  logic [PIX_W-1:0]      rd_color_q;
  logic [DEPTH_BITS-1:0] rd_depth_q;

  logic                  pass;
  logic                  is_read;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [DEPTH_BITS-1:0] mem_wdepth;

  logic                  out_valid_q;
  logic [COLOR_W-1:0]    red_q, green_q, blue_q;
  logic [DEPTH_BITS-1:0] depth_q;
  logic                  pixel_updated_q, out_of_range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ACTIVE_WIDTH_RST;
      height_q <= ACTIVE_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ACTIVE_WIDTH:  width_q  <= cfg_data_i;
        REG_ACTIVE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q    <= op_e'(op_i);
      x_q     <= pixel_x_i;
      y_q     <= pixel_y_i;
      z_q     <= depth_in_i;
      color_q <= {red_in_i, green_in_i, blue_in_i};
    end
  end

  // Register sizes above the store dimensions saturate at the maximum.
  assign eff_w = (WW'(width_q) > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(width_q);
  assign eff_h = (WH'(height_q) > WH'(MAX_HEIGHT)) ? WH'(MAX_HEIGHT) : WH'(height_q);

  assign inside_d = (WW'(x_q) < eff_w) && (WH'(y_q) < eff_h);
  assign addr_ext = EW'(y_q) * EW'(eff_w) + EW'(x_q);
  assign total_d  = TW'(eff_w) * TW'(eff_h);

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      addr_q   <= addr_ext[ADDR_W-1:0];
      total_q  <= total_d;
      inside_q <= inside_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
    end else if (cmd_i.latch) begin
      cursor_q <= '0;
    end else if (cmd_i.clear_step) begin
      cursor_q <= cursor_q + TW'(1);
    end
  end

  assign pass    = (op_q == OP_WRITE) && inside_q && (z_q < rd_depth_q);
  assign is_read = (op_q == OP_READ) && inside_q;

  assign mem_we     = cmd_i.clear_step || (cmd_i.exec && pass);
  assign mem_waddr  = cmd_i.clear_step ? cursor_q[ADDR_W-1:0] : addr_q;
  assign mem_wdepth = cmd_i.clear_step ? '1 : z_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      color_mem[mem_waddr] <= color_q;
      depth_mem[mem_waddr] <= mem_wdepth;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) begin
      rd_color_q <= color_mem[addr_q];
      rd_depth_q <= depth_mem[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      red_q           <= is_read ? rd_color_q[3*COLOR_W-1:2*COLOR_W] : '0;
      green_q         <= is_read ? rd_color_q[2*COLOR_W-1:COLOR_W] : '0;
      blue_q          <= is_read ? rd_color_q[COLOR_W-1:0] : '0;
      depth_q         <= is_read ? rd_depth_q : '0;
      pixel_updated_q <= pass;
      out_of_range_q  <= ((op_q == OP_WRITE) || (op_q == OP_READ)) && !inside_q;
    end
  end

  assign status_o.op         = op_q;
  assign status_o.clear_done = (cursor_q >= total_q);
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign red_out_o       = red_q;
  assign green_out_o     = green_q;
  assign blue_out_o      = blue_q;
  assign depth_out_o     = depth_q;
  assign pixel_updated_o = pixel_updated_q;
  assign out_of_range_o  = out_of_range_q;

  `DTPS_ASSERT_NOW(a_update_inside, clk_i, rst_ni, out_valid_q && pixel_updated_q, !out_of_range_q)
  `DTPS_ASSERT_NOW(a_step_below_total, clk_i, rst_ni, cmd_i.clear_step, cursor_q < total_q)

endmodule

// ----- design/depth_tested_pixel_store.sv -----
// A write or read passes the address, memory read and update steps before its result is
// registered, an unused code the address and update steps, and a clear the address step, a
// sweep over width*height pixels of the effective sizes and the update step. A clear sweeps
// one pixel per cycle; a held result stalls; no request is taken until the last is registered.
// Reset clears the controller, the output valid and the clear cursor and sets both active
// sizes to 256; pixel contents are undefined until a clear.
module depth_tested_pixel_store
  import dtps_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            op_i,
  input  logic [COORD_W-1:0]    pixel_x_i,
  input  logic [COORD_W-1:0]    pixel_y_i,
  input  logic [DEPTH_BITS-1:0] depth_in_i,
  input  logic [COLOR_W-1:0]    red_in_i,
  input  logic [COLOR_W-1:0]    green_in_i,
  input  logic [COLOR_W-1:0]    blue_in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COLOR_W-1:0]    red_out_o,
  output logic [COLOR_W-1:0]    green_out_o,
  output logic [COLOR_W-1:0]    blue_out_o,
  output logic [DEPTH_BITS-1:0] depth_out_o,
  output logic                  pixel_updated_o,
  output logic                  out_of_range_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  dtps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dtps_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .op_i            (op_i),
    .pixel_x_i       (pixel_x_i),
    .pixel_y_i       (pixel_y_i),
    .depth_in_i      (depth_in_i),
    .red_in_i        (red_in_i),
    .green_in_i      (green_in_i),
    .blue_in_i       (blue_in_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .red_out_o       (red_out_o),
    .green_out_o     (green_out_o),
    .blue_out_o      (blue_out_o),
    .depth_out_o     (depth_out_o),
    .pixel_updated_o (pixel_updated_o),
    .out_of_range_o  (out_of_range_o)
  );

endmodule
